@@ src/dot_pkg.sv @@
// Shared types and codes for the deadline-ordered event table.
package dot_pkg;

   localparam int unsigned ID_W  = 16;
   localparam int unsigned DL_W  = 64;
   localparam int unsigned TOL_W = 20;
   localparam int unsigned MAX_RESULTS = 32;
   localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_REARM  = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [DL_W-1:0] dl;
      logic            armed;
   } entry_type;

   typedef struct packed {
      logic       idle;
      logic       ins_read;
      logic       ins_shift;
      logic       ins_place;
      logic       rem_read;
      logic       rem_step;
      logic       rem_finish;
      logic       tk_read;
      logic       tk_skip;
      logic       tk_fire;
      logic       tk_end;
      logic       push_resp;
      status_type status;
   } dot_cmd_type;

   typedef struct packed {
      logic   start;
      op_type start_op;
      logic   full;
      op_type item_op;
      logic   pos_zero;
      logic   rd_gt;
      logic   k_at_count;
      logic   found;
      logic   tick_stop;
      logic   rd_armed;
      logic   rd_due;
      logic   pend_valid;
      logic   out_free;
   } dot_sts_type;

endpackage

@@ src/deadline_ordered_event_table.sv @@
// Top level of the deadline-ordered event table.
//
// req_*: one operation per transfer (insert, remove, rearm, tick), op in tuser.
// rsp_*: result transfers; tlast marks the final result of an operation.
// csr_*: write of the due tolerance, always ready; write only when idle.
// One operation is taken at a time; req_tready is high only when idle.
// Entries sit in a single-port-write, single-port-read memory with registered
// read data, so every entry visited is first read, then evaluated.
// Insert moves each entry with a later deadline down one place, from the
// bottom up, then writes the new entry. Remove walks every entry, moving
// those after the match up one place. Rearm: remove followed by insert. Tick
// fires due armed entries in order until one is not due; at most 32 results.
// Reset empties the table and clears the tolerance; no clearing pass.
// A stalled result receiver holds the output register; a tick walk waits
// when a second fired entry finds the register still occupied.
module deadline_ordered_event_table #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // conn_id, deadline, now_us
   input  logic [1:0]   req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,   // fired_id, fired_deadline
   output logic [1:0]   rsp_tuser,   // status
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [23:0]  csr_data     // due_tolerance_us
);
   import dot_pkg::*;

   dot_cmd_type cmd;
   dot_sts_type sts;

   dot_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   dot_path #(.CAPACITY(CAPACITY)) u_path (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

@@ src/dot_ctrl.sv @@
// Controller state machine sequencing the table walks.
module dot_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  dot_pkg::dot_sts_type sts,
   output dot_pkg::dot_cmd_type cmd
);
   import dot_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_INS_RD = 9'b000000010,
      S_INS_EV = 9'b000000100,
      S_REM_RD = 9'b000001000,
      S_REM_EV = 9'b000010000,
      S_TK_RD  = 9'b000100000,
      S_TK_EV  = 9'b001000000,
      S_TK_END = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   status_type resp_ff, resp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         resp_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         resp_ff  <= resp_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      resp_in    = resp_ff;
      cmd        = '0;
      cmd.status = resp_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.start) begin
               case (sts.start_op)
                  OP_INSERT: begin
                     if (sts.full) begin
                        resp_in  = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  OP_REMOVE, OP_REARM: state_in = S_REM_RD;
                  default: state_in = S_TK_RD;
               endcase
            end
         end
         S_INS_RD: begin
            if (sts.pos_zero) begin
               cmd.ins_place = 1'b1;
               resp_in  = ST_OK;
               state_in = S_RESP;
            end else begin
               cmd.ins_read = 1'b1;
               state_in = S_INS_EV;
            end
         end
         S_INS_EV: begin
            if (sts.rd_gt) begin
               cmd.ins_shift = 1'b1;
               state_in = S_INS_RD;
            end else begin
               cmd.ins_place = 1'b1;
               resp_in  = ST_OK;
               state_in = S_RESP;
            end
         end
         S_REM_RD: begin
            if (sts.k_at_count) begin
               if (sts.found) begin
                  cmd.rem_finish = 1'b1;
                  if (sts.item_op == OP_REARM) begin
                     state_in = S_INS_RD;
                  end else begin
                     resp_in  = ST_OK;
                     state_in = S_RESP;
                  end
               end else begin
                  resp_in  = ST_NOTFOUND;
                  state_in = S_RESP;
               end
            end else begin
               cmd.rem_read = 1'b1;
               state_in = S_REM_EV;
            end
         end
         S_REM_EV: begin
            cmd.rem_step = 1'b1;
            state_in = S_REM_RD;
         end
         S_TK_RD: begin
            if (sts.tick_stop) begin
               state_in = S_TK_END;
            end else begin
               cmd.tk_read = 1'b1;
               state_in = S_TK_EV;
            end
         end
         S_TK_EV: begin
            if (!sts.rd_armed) begin
               cmd.tk_skip = 1'b1;
               state_in = S_TK_RD;
            end else if (!sts.rd_due) begin
               state_in = S_TK_END;
            end else if (!sts.pend_valid || sts.out_free) begin
               cmd.tk_fire = 1'b1;
               state_in = S_TK_RD;
            end
         end
         S_TK_END: begin
            if (sts.out_free) begin
               cmd.tk_end = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.push_resp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ src/dot_path.sv @@
// Datapath: entry memory, walk counters, comparators and result register.
module dot_path #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [143:0]         req_tdata,   // conn_id, deadline, now_us
   input  logic [1:0]           req_tuser,   // op
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [79:0]          rsp_tdata,   // fired_id, fired_deadline
   output logic [1:0]           rsp_tuser,   // status
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [23:0]          csr_data,    // due_tolerance_us
   input  dot_pkg::dot_cmd_type cmd,
   output dot_pkg::dot_sts_type sts
);
   import dot_pkg::*;

   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [NW-1:0] MAXR_C = NW'(MAX_RESULTS);

   entry_type mem [CAPACITY];
   entry_type rd_ff;

   logic [TOL_W-1:0] tol_ff, tol_in;
   logic [CW-1:0]    count_ff, count_in, pos_ff, pos_in, k_ff, k_in;
   logic [NW-1:0]    n_ff, n_in;
   logic             found_ff, found_in, pend_v_ff, pend_v_in;
   entry_type        pend_ff, pend_in;
   op_type           op_ff, op_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [DL_W-1:0]  dl_ff, dl_in, lim_ff, lim_in;
   logic             rsp_v_ff, rsp_v_in, rsp_last_ff, rsp_last_in;
   status_type       rsp_st_ff, rsp_st_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [DL_W-1:0]  rsp_dl_ff, rsp_dl_in;

   logic          start, out_free, we, re;
   logic [IW-1:0] wa, ra;
   entry_type     wd;
   logic [DL_W:0] lim_sum;

   assign start      = req_tvalid && cmd.idle;
   assign req_tready = cmd.idle;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_v_ff || rsp_tready;
   assign lim_sum    = {1'b0, req_tdata[143:80]} + {{(DL_W + 1 - TOL_W){1'b0}}, tol_ff};

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff    <= '0;
         count_ff  <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         tol_ff    <= tol_in;
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
         found_ff  <= found_in;
      end
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      pend_ff     <= pend_in;
      op_ff       <= op_in;
      id_ff       <= id_in;
      dl_ff       <= dl_in;
      lim_ff      <= lim_in;
      rsp_last_ff <= rsp_last_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_dl_ff   <= rsp_dl_in;
   end

   always_comb begin
      tol_in      = csr_valid ? csr_data[TOL_W-1:0] : tol_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      found_in    = found_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      dl_in       = dl_ff;
      lim_in      = lim_ff;
      rsp_v_in    = rsp_v_ff && !rsp_tready;
      rsp_last_in = rsp_last_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_dl_in   = rsp_dl_ff;
      we = 1'b0;
      re = 1'b0;
      wa = '0;
      ra = '0;
      wd = rd_ff;

      if (start) begin
         op_in     = op_type'(req_tuser);
         id_in     = req_tdata[15:0];
         dl_in     = req_tdata[79:16];
         lim_in    = lim_sum[DL_W] ? '1 : lim_sum[DL_W-1:0];
         pos_in    = count_ff;
         k_in      = '0;
         n_in      = '0;
         found_in  = 1'b0;
         pend_v_in = 1'b0;
      end
      if (cmd.ins_read) begin
         re = 1'b1;
         ra = IW'(pos_ff - 1'b1);
      end
      if (cmd.ins_shift) begin
         we = 1'b1;
         wa = pos_ff[IW-1:0];
         pos_in = pos_ff - 1'b1;
      end
      if (cmd.ins_place) begin
         we = 1'b1;
         wa = pos_ff[IW-1:0];
         wd = '{id: id_ff, dl: dl_ff, armed: 1'b1};
         count_in = count_ff + 1'b1;
      end
      if (cmd.rem_read || cmd.tk_read) begin
         re = 1'b1;
         ra = k_ff[IW-1:0];
      end
      if (cmd.rem_step) begin
         if (found_ff) begin
            we = 1'b1;
            wa = IW'(k_ff - 1'b1);
         end else if (rd_ff.id == id_ff) begin
            found_in = 1'b1;
         end
         k_in = k_ff + 1'b1;
      end
      if (cmd.rem_finish) begin
         count_in = count_ff - 1'b1;
         pos_in   = count_ff - 1'b1;
      end
      if (cmd.tk_skip) begin
         k_in = k_ff + 1'b1;
      end
      if (cmd.tk_fire) begin
         if (pend_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_st_in   = ST_OK;
            rsp_id_in   = pend_ff.id;
            rsp_dl_in   = pend_ff.dl;
            rsp_last_in = 1'b0;
         end
         we = 1'b1;
         wa = k_ff[IW-1:0];
         wd = '{id: rd_ff.id, dl: rd_ff.dl, armed: 1'b0};
         pend_in   = rd_ff;
         pend_v_in = 1'b1;
         n_in = n_ff + 1'b1;
         k_in = k_ff + 1'b1;
      end
      if (cmd.tk_end) begin
         rsp_v_in    = 1'b1;
         rsp_last_in = 1'b1;
         if (pend_v_ff) begin
            rsp_st_in = ST_OK;
            rsp_id_in = pend_ff.id;
            rsp_dl_in = pend_ff.dl;
         end else begin
            rsp_st_in = ST_NONE;
            rsp_id_in = id_ff;
            rsp_dl_in = '0;
         end
      end
      if (cmd.push_resp) begin
         rsp_v_in    = 1'b1;
         rsp_last_in = 1'b1;
         rsp_st_in   = cmd.status;
         rsp_id_in   = id_ff;
         rsp_dl_in   = '0;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {rsp_dl_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      sts            = '0;
      sts.start      = start;
      sts.start_op   = op_type'(req_tuser);
      sts.full       = (count_ff == CAP_C);
      sts.item_op    = op_ff;
      sts.pos_zero   = (pos_ff == '0);
      sts.rd_gt      = (rd_ff.dl > dl_ff);
      sts.k_at_count = (k_ff == count_ff);
      sts.found      = found_ff;
      sts.tick_stop  = (k_ff == count_ff) || (n_ff == MAXR_C);
      sts.rd_armed   = rd_ff.armed;
      sts.rd_due     = (rd_ff.dl <= lim_ff);
      sts.pend_valid = pend_v_ff;
      sts.out_free   = out_free;
   end

endmodule

@@ src/dot_checker.sv @@
// Port-level checks for the event table, bound to the top level.
module dot_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [79:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);
   import dot_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second operation taken while busy");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tlast)
      else $error("error result not final");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata[79:16] == '0))
      else $error("error result carries a deadline");

endmodule

bind deadline_ordered_event_table dot_checker u_dot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/sv/tb_deadline_ordered_event_table.sv @@
// Self-checking testbench for the deadline-ordered event table.
module tb_deadline_ordered_event_table;
   import dot_pkg::*;

   typedef struct {
      status_type st;
      logic [15:0] id;
      logic [63:0] dl;
      logic        last;
   } event_result_type;

   class event_table_scoreboard;
      logic [15:0]      ids [32];
      logic [63:0]      dls [32];
      logic             armed [32];
      int               count;
      logic [19:0]      tol;
      event_result_type awaited [$];
      int               errors;

      function new();
         count = 0;
         tol = '0;
         errors = 0;
         foreach (armed[i]) armed[i] = 1'b0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function int pending();
         return awaited.size();
      endfunction

      function void push(status_type st, logic [15:0] id, logic [63:0] dl, logic last);
         event_result_type r;
         r.st = st; r.id = id; r.dl = dl; r.last = last;
         awaited.push_back(r);
      endfunction

      function void take_out(int pos);
         for (int i = pos; i + 1 < count; i++) begin
            ids[i] = ids[i+1]; dls[i] = dls[i+1]; armed[i] = armed[i+1];
         end
         count--;
      endfunction

      function void put_in(logic [15:0] id, logic [63:0] dl);
         int pos;
         pos = 0;
         while (pos < count && dls[pos] <= dl) pos++;
         for (int i = count; i > pos; i--) begin
            ids[i] = ids[i-1]; dls[i] = dls[i-1]; armed[i] = armed[i-1];
         end
         ids[pos] = id; dls[pos] = dl; armed[pos] = 1'b1;
         count++;
      endfunction

      function void note_item(op_type op, logic [15:0] id, logic [63:0] dl, logic [63:0] now);
         int pos;
         int n;
         logic [64:0] sum;
         logic [63:0] limit;
         pos = -1;
         n = 0;
         case (op)
            OP_INSERT: begin
               if (count >= 32) push(ST_FULL, id, '0, 1'b1);
               else begin
                  put_in(id, dl);
                  push(ST_OK, id, '0, 1'b1);
               end
            end
            OP_REMOVE, OP_REARM: begin
               for (int i = 0; i < count; i++)
                  if (pos < 0 && ids[i] == id) pos = i;
               if (pos < 0) push(ST_NOTFOUND, id, '0, 1'b1);
               else begin
                  take_out(pos);
                  if (op == OP_REARM) put_in(id, dl);
                  push(ST_OK, id, '0, 1'b1);
               end
            end
            default: begin
               sum = {1'b0, now} + {45'b0, tol};
               limit = sum[64] ? '1 : sum[63:0];
               for (int i = 0; i < count && n < 32; i++) begin
                  if (armed[i]) begin
                     if (dls[i] > limit) break;
                     push(ST_OK, ids[i], dls[i], 1'b0);
                     armed[i] = 1'b0;
                     n++;
                  end
               end
               if (n == 0) push(ST_NONE, id, '0, 1'b1);
               else awaited[$].last = 1'b1;
            end
         endcase
      endfunction

      task check_result(status_type st, logic [15:0] id, logic [63:0] dl, logic last);
         event_result_type e;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result st=%0d id=%h", st, id));
         end else begin
            e = awaited.pop_front();
            if (st !== e.st) report($sformatf("status %0d, want %0d", st, e.st));
            if (id !== e.id) report($sformatf("id %h, want %h", id, e.id));
            if (dl !== e.dl) report($sformatf("deadline %h, want %h", dl, e.dl));
            if (last !== e.last) report($sformatf("last %b, want %b", last, e.last));
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [23:0]  csr_data = '0;

   event_table_scoreboard sb = new();
   bit           no_idle = 1'b0;
   logic [63:0]  base_us = 64'd1000;

   deadline_ordered_event_table dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_item(op_type'(req_tuser), req_tdata[15:0], req_tdata[79:16],
                      req_tdata[143:80]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(status_type'(rsp_tuser), rsp_tdata[15:0], rsp_tdata[79:16],
                         rsp_tlast);
   end

   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 8);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task send_op(op_type op, logic [15:0] id, logic [63:0] dl, logic [63:0] now);
      int n;
      n = no_idle ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {now, dl, id};
      do @(posedge clock); while (!req_tready);
   endtask

   // pause until every result is in and the block has settled
   task drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task write_tolerance(logic [19:0] v);
      csr_valid <= 1'b1;
      csr_data  <= {4'b0, v};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.tol = v;
   endtask

   function logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task random_op;
      int          sel;
      op_type      op;
      logic [15:0] id;
      logic [63:0] dl;
      logic [63:0] now;
      sel = $urandom_range(0, 99);
      op = sel < 35 ? OP_INSERT : sel < 50 ? OP_REMOVE : sel < 70 ? OP_REARM : OP_TICK;
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
         0:       dl = rand64();
         1:       dl = '1;
         2:       dl = '0;
         default: dl = base_us + $urandom_range(0, 3000000);
      endcase
      now = ($urandom_range(0, 9) == 0) ? rand64() : base_us + $urandom_range(0, 2000000);
      base_us = base_us + $urandom_range(0, 400000);
      send_op(op, id, dl, now);
   endtask

   initial begin
      logic [19:0] tols [4];
      tols[0] = 20'd0; tols[1] = 20'd1000000; tols[2] = 20'd500;
      tols[3] = 20'($urandom_range(0, 1000000));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_tolerance(20'd0);
      send_op(OP_INSERT, 16'hFFFF, '1, '0);
      send_op(OP_INSERT, 16'h0000, '0, '0);
      send_op(OP_INSERT, 16'h0000, '0, '1);
      send_op(OP_INSERT, 16'h1234, 64'd5, '0);
      send_op(OP_REMOVE, 16'h7777, '0, '0);
      send_op(OP_REARM, 16'h8888, 64'd9, '0);
      send_op(OP_TICK, 16'hABCD, '0, '0);
      send_op(OP_TICK, 16'h5432, '0, '0);
      send_op(OP_REARM, 16'h0000, 64'd5, '0);
      send_op(OP_REMOVE, 16'h0000, '0, '0);
      send_op(OP_TICK, 16'hFFFF, '1, '1);
      for (int i = 0; i < 30; i++)
         send_op(OP_INSERT, 16'(i % 16), 64'(i * 7 % 11), '0);
      send_op(OP_INSERT, 16'h00AA, 64'd3, '0);
      send_op(OP_TICK, 16'h0001, '1, 64'd20);
      drain();

      write_tolerance(20'd1000000);
      send_op(OP_REARM, 16'h0003, 64'hFFFF_FFFF_FFFF_FFF0, '0);
      send_op(OP_TICK, 16'h0002, '0, 64'hFFFF_FFFF_FFFF_FFFA);
      for (int i = 0; i < 16; i++)
         send_op(OP_REMOVE, 16'(i), '0, '0);

      for (int p = 0; p < 4; p++) begin
         drain();
         write_tolerance(tols[p]);
         no_idle = (p == 2);
         for (int k = 0; k < 22; k++) random_op();
      end
      no_idle = 1'b0;
      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[deadline_ordered_event_table] OK");
      end else begin
         $display("[deadline_ordered_event_table] ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[deadline_ordered_event_table] ERROR");
      $finish;
   end

endmodule
